### src/cffm_pkg.sv
// cffm_pkg: shared types, codes and classification for the contactor feedback fault monitor
// no dependencies; imported by every module of the block

package cffm_pkg;

    // field widths
    localparam int GUN_W  = 3;
    localparam int FB_W   = 2;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DETECT_TIME = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_HOLD  = 1'd1;

    // register reset values
    localparam logic [CFG_W-1:0] DETECT_TIME_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] CLEAR_HOLD_RESET  = 16'd5000;

    // feedback codes
    localparam logic [FB_W-1:0] FB_BOTH_OPEN   = 2'd0;
    localparam logic [FB_W-1:0] FB_PATTERN_0X  = 2'd1;
    localparam logic [FB_W-1:0] FB_PATTERN_X0  = 2'd2;
    localparam logic [FB_W-1:0] FB_BOTH_CLOSED = 2'd3;

    // per-contactor verdict of one poll
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_MISMATCH = 2'd1,
        KIND_MATCH    = 2'd2
    } cffm_kind_t;

    // stored state of one contactor
    typedef struct packed {
        logic [TIME_W-1:0] mismatch_start;
        logic [TIME_W-1:0] fault_set_time;
        logic              fault;
    } cffm_slot_t;

    // classify drive against feedback for one contactor
    function automatic cffm_kind_t cffm_classify(input logic drive,
                                                 input logic [FB_W-1:0] fb,
                                                 input logic second);
        logic good;
        logic both_wrong;
        logic own_side;
        cffm_kind_t kind;
        good       = (drive && fb == FB_BOTH_CLOSED) || (!drive && fb == FB_BOTH_OPEN);
        both_wrong = (drive && fb == FB_BOTH_OPEN) || (!drive && fb == FB_BOTH_CLOSED);
        own_side   = second ? (fb == FB_PATTERN_0X) : (fb == FB_PATTERN_X0);
        if (good)
            kind = KIND_MATCH;
        else if (both_wrong || own_side)
            kind = KIND_MISMATCH;
        else
            kind = KIND_NONE;
        return kind;
    endfunction

endpackage

### src/cffm_judge.sv
// cffm_judge: next-state logic of one contactor for one poll
// depends on cffm_pkg for the slot type and the verdict codes

module cffm_judge
    import cffm_pkg::*;
(
    input  cffm_kind_t        kind,
    input  cffm_slot_t        cur,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [CFG_W-1:0]  detect_time_ms,
    input  logic [CFG_W-1:0]  clear_hold_ms,
    output cffm_slot_t        nxt
);

    logic [TIME_W-1:0] since_match;
    logic [TIME_W-1:0] since_fault;
    logic              detect_hit;
    logic              clear_hit;

    // elapsed times, wrapping modulo 2^32
    assign since_match = now_ms - cur.mismatch_start;
    assign since_fault = now_ms - cur.fault_set_time;
    assign detect_hit  = since_match >= {{(TIME_W-CFG_W){1'b0}}, detect_time_ms};
    assign clear_hit   = since_fault >= {{(TIME_W-CFG_W){1'b0}}, clear_hold_ms};

    // latch on long mismatch, restart timer and maybe clear on good match
    always_comb
    begin
        nxt = cur;
        case (kind)
            KIND_MISMATCH:
            begin
                if (detect_hit && !cur.fault)
                begin
                    nxt.fault          = 1'b1;
                    nxt.fault_set_time = now_ms;
                end
            end
            KIND_MATCH:
            begin
                nxt.mismatch_start = now_ms;
                if (cur.fault && clear_hit)
                    nxt.fault = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### src/cffm_state.sv
// cffm_state: per-gun contactor state rows, one row read and written per cycle while wr_en is high
// depends on cffm_pkg for the slot type

module cffm_state
    import cffm_pkg::*;
#(
    parameter int GUNS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [GUN_W-1:0] row_sel,
    input  logic       wr_en,
    input  cffm_slot_t wr_slot1,
    input  cffm_slot_t wr_slot2,
    output cffm_slot_t rd_slot1,
    output cffm_slot_t rd_slot2
);

    localparam int ROW_W = (GUNS > 1) ? $clog2(GUNS) : 1;

    cffm_slot_t slot1_reg [GUNS];
    cffm_slot_t slot2_reg [GUNS];
    logic [ROW_W-1:0] row;

    assign row = row_sel[ROW_W-1:0];

    // read the selected row
    assign rd_slot1 = slot1_reg[row];
    assign rd_slot2 = slot2_reg[row];

    // write back the selected row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GUNS; i++)
            begin
                slot1_reg[i] <= '0;
                slot2_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            slot1_reg[row] <= wr_slot1;
            slot2_reg[row] <= wr_slot2;
        end
    end

endmodule

### src/contactor_feedback_fault_monitor_top.sv
// contactor_feedback_fault_monitor_top: top level of the contactor feedback fault monitor
// depends on cffm_pkg, cffm_state and cffm_judge
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll of one gun: gun, drive_on,
//   feedback_code and now_ms. Output channel (out_valid / out_stall) returns one
//   result per poll: gun_out and the two latched contactor fault flags after it.
//   A transaction happens at a rising edge with valid high and stall low.
//   Throughput: one poll per cycle while out_stall is low; the poll register feeds
//   the compare and write-back logic, which loads the result register, so
//   back-to-back polls of the same gun see each other's updates with no forwarding.
//   When the receiver stalls, the result register holds; the poll register then
//   holds too and in_stall rises once it is full, so at most two polls are in flight.
//   Gun indexes at or above GUNS leave the state untouched and report no faults.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the edge;
//   write them only while the block is idle.
//   Reset: all faults cleared, timestamps zeroed, detect time 1000 ms and clear
//   hold 5000 ms, both channels empty.

module contactor_feedback_fault_monitor_top
    import cffm_pkg::*;
#(
    parameter int GUNS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // poll input
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [GUN_W-1:0]       gun,
    input  logic                   drive_on,
    input  logic [FB_W-1:0]        feedback_code,
    input  logic [TIME_W-1:0]      now_ms,
    // result output
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [GUN_W-1:0]       gun_out,
    output logic                   contactor1_fault,
    output logic                   contactor2_fault
);

    logic [CFG_W-1:0]  detect_time_reg;
    logic [CFG_W-1:0]  clear_hold_reg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [GUN_W-1:0]  gun_reg;
    logic              drive_reg;
    logic [FB_W-1:0]   fb_reg;
    logic [TIME_W-1:0] now_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [GUN_W-1:0]  gun_out_reg;
    logic              fault1_reg;
    logic              fault2_reg;

    logic              accept;
    logic              advance;
    logic              in_range;
    cffm_kind_t        kind1;
    cffm_kind_t        kind2;
    cffm_slot_t        cur1;
    cffm_slot_t        cur2;
    cffm_slot_t        nxt1;
    cffm_slot_t        nxt2;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_time_reg <= DETECT_TIME_RESET;
            clear_hold_reg  <= CLEAR_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DETECT_TIME: detect_time_reg <= cfg_data;
                CFG_CLEAR_HOLD:  clear_hold_reg  <= cfg_data;
                default:         detect_time_reg <= detect_time_reg;
            endcase
        end
    end

    // handshake: the poll moves on whenever the result register is empty or being taken
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // poll register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gun_reg   <= gun;
            drive_reg <= drive_on;
            fb_reg    <= feedback_code;
            now_reg   <= now_ms;
        end
    end

    // classify the poll per contactor
    assign in_range = {{(32-GUN_W){1'b0}}, gun_reg} < 32'(GUNS);
    assign kind1    = cffm_classify(drive_reg, fb_reg, 1'b0);
    assign kind2    = cffm_classify(drive_reg, fb_reg, 1'b1);

    // state rows
    cffm_state #(
        .GUNS (GUNS)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .row_sel  (gun_reg),
        .wr_en    (advance && in_range),
        .wr_slot1 (nxt1),
        .wr_slot2 (nxt2),
        .rd_slot1 (cur1),
        .rd_slot2 (cur2)
    );

    // next state of each contactor
    cffm_judge u_judge1 (
        .kind           (kind1),
        .cur            (cur1),
        .now_ms         (now_reg),
        .detect_time_ms (detect_time_reg),
        .clear_hold_ms  (clear_hold_reg),
        .nxt            (nxt1)
    );

    cffm_judge u_judge2 (
        .kind           (kind2),
        .cur            (cur2),
        .now_ms         (now_reg),
        .detect_time_ms (detect_time_reg),
        .clear_hold_ms  (clear_hold_reg),
        .nxt            (nxt2)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gun_out_reg <= gun_reg;
            fault1_reg  <= in_range && nxt1.fault;
            fault2_reg  <= in_range && nxt2.fault;
        end
    end

    assign out_valid        = out_valid_reg;
    assign gun_out          = gun_out_reg;
    assign contactor1_fault = fault1_reg;
    assign contactor2_fault = fault2_reg;

endmodule
